FILE: rtl/core/aft_pkg.sv
// Package for the box-versus-frustum culling block.
// Holds plane register packing, field widths and fixed-point constants.
// No dependencies.
package aft_pkg;

    localparam int FIELD_W   = 16;  // width of every box field and plane part
    localparam int PLANE_W   = 64;  // width of one plane register
    localparam int REG_COUNT = 6;   // plane registers that exist
    localparam int CFG_IDX_W = 3;   // register index width
    localparam int NORM_FRAC = 14;  // fraction bits of the Q1.14 normal

    // Packed plane register: w in bits 63:48, nz 47:32, ny 31:16, nx 15:0.
    typedef struct packed {
        logic signed [FIELD_W-1:0] w;
        logic signed [FIELD_W-1:0] nz;
        logic signed [FIELD_W-1:0] ny;
        logic signed [FIELD_W-1:0] nx;
    } plane_t;

endpackage

FILE: rtl/core/aft_cell.sv
// One cell of the culling chain: tests the passing box against one plane.
// Two register stages: near-corner products, then sum and sign test.
// Depends on aft_pkg.
module aft_cell #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  aft_pkg::plane_t                          plane,
    input  logic                                     up_valid,
    output logic                                     up_ready,
    input  logic [aft_pkg::FIELD_W-1:0]              up_tag,
    input  logic [2:0][COORD_WIDTH-1:0]              up_lo,
    input  logic [2:0][COORD_WIDTH-1:0]              up_hi,
    input  logic                                     up_inside,
    output logic                                     dn_valid,
    input  logic                                     dn_ready,
    output logic [aft_pkg::FIELD_W-1:0]              dn_tag,
    output logic [2:0][COORD_WIDTH-1:0]              dn_lo,
    output logic [2:0][COORD_WIDTH-1:0]              dn_hi,
    output logic                                     dn_inside
);
    import aft_pkg::*;

    localparam int PROD_W = FIELD_W + COORD_WIDTH;
    localparam int WT_W   = FIELD_W + NORM_FRAC;
    localparam int ACC_W  = ((PROD_W > WT_W) ? PROD_W : WT_W) + 2;

    // Stage A: products
    logic                          valid_a_reg;
    logic [FIELD_W-1:0]            tag_a_reg;
    logic [2:0][COORD_WIDTH-1:0]   lo_a_reg;
    logic [2:0][COORD_WIDTH-1:0]   hi_a_reg;
    logic                          inside_a_reg;
    logic signed [PROD_W-1:0]      prod_a_reg [3];
    logic signed [PROD_W-1:0]      prod_next  [3];

    // Stage B: verdict
    logic                          valid_b_reg;
    logic [FIELD_W-1:0]            tag_b_reg;
    logic [2:0][COORD_WIDTH-1:0]   lo_b_reg;
    logic [2:0][COORD_WIDTH-1:0]   hi_b_reg;
    logic                          inside_b_reg;
    logic                          inside_next;

    logic                          ready_a;
    logic                          ready_b;
    logic signed [FIELD_W-1:0]     norm [3];
    logic signed [COORD_WIDTH-1:0] near [3];
    logic signed [PROD_W-1:0]      norm_ext [3];
    logic signed [PROD_W-1:0]      near_ext [3];
    logic signed [ACC_W-1:0]       acc;

    assign ready_b  = !valid_b_reg || dn_ready;
    assign ready_a  = !valid_a_reg || ready_b;
    assign up_ready = ready_a;

    assign norm[0] = plane.nx;
    assign norm[1] = plane.ny;
    assign norm[2] = plane.nz;

    // Pick the near corner per axis: min where the normal is positive, else max.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            near[a]      = (norm[a] > 0) ? signed'(up_lo[a]) : signed'(up_hi[a]);
            norm_ext[a]  = PROD_W'(norm[a]);
            near_ext[a]  = PROD_W'(near[a]);
            prod_next[a] = norm_ext[a] * near_ext[a];
        end
    end

    always_comb
    begin
        acc = ACC_W'(prod_a_reg[0]) + ACC_W'(prod_a_reg[1]) + ACC_W'(prod_a_reg[2])
            + (ACC_W'(plane.w) <<< NORM_FRAC);
        // Strictly positive test value means the box lies outside this plane.
        inside_next = inside_a_reg && (acc[ACC_W-1] || (acc == '0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
                valid_a_reg <= up_valid;
            if (ready_b)
                valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_a && up_valid)
        begin
            tag_a_reg    <= up_tag;
            lo_a_reg     <= up_lo;
            hi_a_reg     <= up_hi;
            inside_a_reg <= up_inside;
            for (int a = 0; a < 3; a++)
                prod_a_reg[a] <= prod_next[a];
        end
        if (ready_b && valid_a_reg)
        begin
            tag_b_reg    <= tag_a_reg;
            lo_b_reg     <= lo_a_reg;
            hi_b_reg     <= hi_a_reg;
            inside_b_reg <= inside_next;
        end
    end

    assign dn_valid  = valid_b_reg;
    assign dn_tag    = tag_b_reg;
    assign dn_lo     = lo_b_reg;
    assign dn_hi     = hi_b_reg;
    assign dn_inside = inside_b_reg;

endmodule

FILE: rtl/core/aabb_frustum_cull_test.sv
// Top level of the box-versus-frustum culling block.
// Holds the plane registers and a chain of aft_cell instances, one per plane.
// Depends on aft_pkg and aft_cell.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one box per transaction: a tag
//   and the min and max corners. Output channel (out_valid / out_stall)
//   returns one transaction per box: the tag and inside_res (1 = keep,
//   0 = culled by at least one plane).
//   Planes are written through cfg_we / cfg_index / cfg_data while the chain
//   is empty; indexes beyond the sixth register are ignored. Plane slots past
//   the sixth read as zero and never cull.
//   In each cell a box passes the stage for the three near-corner products,
//   then the stage for the sum and sign test.
//   Throughput: one box per cycle while out_stall is low, set by the chain
//   advancing one cell stage per cycle.
//   Stall: each stage holds while the stage after it is full and held, so a
//   stalled result sits in the last cell's output register while the empty
//   stages ahead of it keep taking boxes. in_stall rises only once every
//   stage is full and out_stall is high.
//   Reset clears all stage valid bits and all plane registers to zero.
module aabb_frustum_cull_test #(
    parameter int NUM_PLANES  = 6,
    parameter int COORD_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [aft_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [aft_pkg::PLANE_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [aft_pkg::FIELD_W-1:0]         box_tag,
    input  logic signed [aft_pkg::FIELD_W-1:0]  min_x,
    input  logic signed [aft_pkg::FIELD_W-1:0]  min_y,
    input  logic signed [aft_pkg::FIELD_W-1:0]  min_z,
    input  logic signed [aft_pkg::FIELD_W-1:0]  max_x,
    input  logic signed [aft_pkg::FIELD_W-1:0]  max_y,
    input  logic signed [aft_pkg::FIELD_W-1:0]  max_z,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [aft_pkg::FIELD_W-1:0]         result_tag,
    output logic                                inside_res
);
    import aft_pkg::*;

    localparam int DEPTH = 2 * NUM_PLANES;           // stage registers in the chain
    localparam int CNT_W = $clog2(DEPTH + 1);

    plane_t plane_reg [REG_COUNT];
    plane_t plane_sel [NUM_PLANES];

    // Chain links: link k feeds cell k, link NUM_PLANES is the output.
    logic                          link_valid  [NUM_PLANES+1];
    logic                          link_ready  [NUM_PLANES+1];
    logic [FIELD_W-1:0]            link_tag    [NUM_PLANES+1];
    logic [2:0][COORD_WIDTH-1:0]   link_lo     [NUM_PLANES+1];
    logic [2:0][COORD_WIDTH-1:0]   link_hi     [NUM_PLANES+1];
    logic                          link_inside [NUM_PLANES+1];

    logic [CNT_W-1:0]              inflight_reg;
    logic [CNT_W-1:0]              inflight_next;

    // Plane registers: drop writes to indexes past the last register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < REG_COUNT; r++)
                plane_reg[r] <= '0;
        end
        else if (cfg_we)
        begin
            for (int r = 0; r < REG_COUNT; r++)
                if (cfg_index == CFG_IDX_W'(r))
                    plane_reg[r] <= plane_t'(cfg_data);
        end
    end

    // Head of the chain: trim or sign-extend each field to COORD_WIDTH.
    assign link_valid[0]  = in_valid;
    assign in_stall       = !link_ready[0];
    assign link_tag[0]    = box_tag;
    assign link_lo[0][0]  = COORD_WIDTH'(min_x);
    assign link_lo[0][1]  = COORD_WIDTH'(min_y);
    assign link_lo[0][2]  = COORD_WIDTH'(min_z);
    assign link_hi[0][0]  = COORD_WIDTH'(max_x);
    assign link_hi[0][1]  = COORD_WIDTH'(max_y);
    assign link_hi[0][2]  = COORD_WIDTH'(max_z);
    assign link_inside[0] = 1'b1;

    for (genvar p = 0; p < NUM_PLANES; p++)
    begin : g_cell
        if (p < REG_COUNT)
        begin : g_reg
            assign plane_sel[p] = plane_reg[p];
        end
        else
        begin : g_zero
            assign plane_sel[p] = '0;
        end

        aft_cell #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .plane     (plane_sel[p]),
            .up_valid  (link_valid[p]),
            .up_ready  (link_ready[p]),
            .up_tag    (link_tag[p]),
            .up_lo     (link_lo[p]),
            .up_hi     (link_hi[p]),
            .up_inside (link_inside[p]),
            .dn_valid  (link_valid[p+1]),
            .dn_ready  (link_ready[p+1]),
            .dn_tag    (link_tag[p+1]),
            .dn_lo     (link_lo[p+1]),
            .dn_hi     (link_hi[p+1]),
            .dn_inside (link_inside[p+1])
        );
    end

    // Tail of the chain: the last cell's stage register is the output register.
    assign link_ready[NUM_PLANES] = !out_stall;
    assign out_valid              = link_valid[NUM_PLANES];
    assign result_tag             = link_tag[NUM_PLANES];
    assign inside_res             = link_inside[NUM_PLANES];

    // Transactions in flight, for the checks below.
    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_valid && !in_stall)
            inflight_next = inflight_next + CNT_W'(1);
        if (out_valid && !out_stall)
            inflight_next = inflight_next - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    // The chain never holds more boxes than it has stages.
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CNT_W'(DEPTH))
        else $error("more transactions in flight than chain stages");

    // An empty chain shows no result.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (inflight_reg == '0) |-> !out_valid)
        else $error("result presented with nothing in flight");

    // An empty chain always takes a box.
    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        (inflight_reg == '0) |-> !in_stall)
        else $error("input stalled while chain is empty");

    // A chain that is not full always takes a box.
    a_not_full_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        (inflight_reg < CNT_W'(DEPTH)) && !(out_valid && out_stall) |-> !in_stall)
        else $error("input stalled while chain has room");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for aabb_frustum_cull_test: a directed table of boxes and plane writes,
// then random phases, all checked against a behavioral n-vertex plane test.
// Depends on aft_pkg and the aabb_frustum_cull_test RTL.
module testbench;
    import aft_pkg::*;

    localparam int     NUM_PLANES  = 6;
    localparam int     LATENCY     = 2 * NUM_PLANES;
    localparam int     RAND_PHASES = 10;
    localparam int     PHASE_BOXES = 100;
    localparam int     W_SCALE     = 1 << NORM_FRAC;
    localparam int     CFG_SLOTS   = 1 << CFG_IDX_W;
    localparam longint TIMEOUT_NS  = 64'd20_000_000;

    // Register map: six plane registers, then two indexes that do not exist.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PLANE0,
        REG_PLANE1,
        REG_PLANE2,
        REG_PLANE3,
        REG_PLANE4,
        REG_PLANE5,
        REG_SPARE6,
        REG_SPARE7
    } plane_reg_e;

    // How a directed row gets its expected verdict.
    typedef enum logic [1:0] {
        VERDICT_PREDICT,
        VERDICT_KEEP,
        VERDICT_CULL
    } verdict_e;

    typedef enum logic {
        ROW_PLANE,
        ROW_BOX
    } row_kind_e;

    typedef struct {
        logic [FIELD_W-1:0]        tag;
        logic signed [FIELD_W-1:0] lo_x;
        logic signed [FIELD_W-1:0] lo_y;
        logic signed [FIELD_W-1:0] lo_z;
        logic signed [FIELD_W-1:0] hi_x;
        logic signed [FIELD_W-1:0] hi_y;
        logic signed [FIELD_W-1:0] hi_z;
    } box_s;

    typedef struct {
        row_kind_e          kind;
        plane_reg_e         reg_idx;
        logic [PLANE_W-1:0] value;
        box_s               box;
        verdict_e           verdict;
    } row_s;

    typedef struct {
        logic [FIELD_W-1:0] tag;
        logic               keep;
    } verdict_s;

    // DUT-facing signals; every input starts at a known value.
    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [PLANE_W-1:0]        cfg_data  = '0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    logic [FIELD_W-1:0]        box_tag   = '0;
    logic signed [FIELD_W-1:0] min_x     = '0;
    logic signed [FIELD_W-1:0] min_y     = '0;
    logic signed [FIELD_W-1:0] min_z     = '0;
    logic signed [FIELD_W-1:0] max_x     = '0;
    logic signed [FIELD_W-1:0] max_y     = '0;
    logic signed [FIELD_W-1:0] max_z     = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [FIELD_W-1:0]        result_tag;
    logic                      inside_res;

    // Shadow copy of the plane registers, the verdicts still owed by the
    // block, and the count of bad result fields.
    logic [PLANE_W-1:0] plane_shadow [REG_COUNT] = '{default: '0};
    verdict_s           awaited_verdicts [$];
    row_s               directed_rows [$];
    int                 bad_fields = 0;
    bit                 valid_up   = 1'b0;
    bit                 we_up      = 1'b0;

    aabb_frustum_cull_test #(
        .NUM_PLANES  (NUM_PLANES),
        .COORD_WIDTH (FIELD_W)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .box_tag    (box_tag),
        .min_x      (min_x),
        .min_y      (min_y),
        .min_z      (min_z),
        .max_x      (max_x),
        .max_y      (max_y),
        .max_z      (max_z),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result_tag (result_tag),
        .inside_res (inside_res)
    );

    initial
    begin : clock_gen
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Behavioral plane test
    // ------------------------------------------------------------------

    // Pick the near corner on one axis: min where the normal points up,
    // max otherwise (a zero normal picks max, which adds nothing anyway).
    function automatic longint near_term(logic signed [FIELD_W-1:0] n,
                                         logic signed [FIELD_W-1:0] lo,
                                         logic signed [FIELD_W-1:0] hi);
        return (n > 0) ? longint'(n) * longint'(lo) : longint'(n) * longint'(hi);
    endfunction

    // Return 1 when no plane puts the box's near corner strictly outside.
    // Sums stay exact in 64 bits: |n*x| <= 2^30 per axis, |w*2^14| <= 2^29.
    function automatic logic box_survives(box_s b);
        plane_t pl;
        longint acc;
        for (int p = 0; p < NUM_PLANES && p < REG_COUNT; p++)
        begin
            pl  = plane_t'(plane_shadow[p]);
            acc = longint'(pl.w) * W_SCALE
                + near_term(pl.nx, b.lo_x, b.hi_x)
                + near_term(pl.ny, b.lo_y, b.hi_y)
                + near_term(pl.nz, b.lo_z, b.hi_z);
            if (acc > 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [PLANE_W-1:0] pack_plane(int nx, int ny, int nz, int w);
        plane_t pl;
        pl.nx = nx[FIELD_W-1:0];
        pl.ny = ny[FIELD_W-1:0];
        pl.nz = nz[FIELD_W-1:0];
        pl.w  = w[FIELD_W-1:0];
        return pl;
    endfunction

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------

    function automatic void add_plane(plane_reg_e idx, logic [PLANE_W-1:0] value);
        row_s r;
        r.kind    = ROW_PLANE;
        r.reg_idx = idx;
        r.value   = value;
        r.verdict = VERDICT_PREDICT;
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    function automatic void add_box(int tag, int lx, int ly, int lz,
                                    int hx, int hy, int hz, verdict_e v);
        row_s r;
        r.kind     = ROW_BOX;
        r.reg_idx  = REG_PLANE0;
        r.value    = '0;
        r.box.tag  = tag[FIELD_W-1:0];
        r.box.lo_x = lx[FIELD_W-1:0];
        r.box.lo_y = ly[FIELD_W-1:0];
        r.box.lo_z = lz[FIELD_W-1:0];
        r.box.hi_x = hx[FIELD_W-1:0];
        r.box.hi_y = hy[FIELD_W-1:0];
        r.box.hi_z = hz[FIELD_W-1:0];
        r.verdict  = v;
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    function automatic void build_directed();
        // Planes are all zero after reset: a zero plane tests to exactly 0
        // and never culls, so every box is kept, inverted ones included.
        add_box(16'h0000,      0,      0,      0,      0,      0,      0, VERDICT_KEEP);
        add_box(16'hFFFF, -32768, -32768, -32768,  32767,  32767,  32767, VERDICT_KEEP);
        add_box(16'h8000,  32767,  32767,  32767, -32768, -32768, -32768, VERDICT_KEEP);
        add_box(16'h5AA5,  32767, -32768,  21845, -21846,     -1,      0, VERDICT_KEEP);

        // Indexes past the sixth register are dropped; the first value would
        // cull these boxes if it landed in a plane slot.
        add_plane(REG_SPARE6, pack_plane(0, 0, 0, 32767));
        add_plane(REG_SPARE7, {PLANE_W{1'b1}});
        add_box(16'h0001, -32768, -32768, -32768, -32768, -32768, -32768, VERDICT_KEEP);
        add_box(16'h0002,    100,    100,    100,    200,    200,    200, VERDICT_KEEP);

        // Unit normal along +x, w = -100: culls when min_x > 100. A box
        // touching the plane sums to zero and is kept.
        add_plane(REG_PLANE0, pack_plane(16384, 0, 0, -100));
        add_box(16'h0010,    100,      0,      0,    200,      0,      0, VERDICT_KEEP);
        add_box(16'h0011,    101,      0,      0,    200,      0,      0, VERDICT_CULL);
        add_box(16'h0012, -32768, -32768, -32768,  32767,  32767,  32767, VERDICT_KEEP);

        // Mirror plane along -x: culls when max_x < -100. The inverted box is
        // tested with its corners as given and falls outside plane 0.
        add_plane(REG_PLANE1, pack_plane(-16384, 0, 0, -100));
        add_box(16'h0013,   -300,      0,      0,   -101,      0,      0, VERDICT_CULL);
        add_box(16'h0014,   -300,      0,      0,   -100,      0,      0, VERDICT_KEEP);
        add_box(16'h0015,    200,      0,      0,   -200,      0,      0, VERDICT_CULL);

        // Extreme planes in the remaining slots; let the predictor decide.
        add_plane(REG_PLANE2, pack_plane(-32768, -32768, -32768, -32768));
        add_plane(REG_PLANE3, pack_plane(32767, 32767, 32767, 32767));
        add_plane(REG_PLANE4, pack_plane(0, 0, 0, 0));
        add_plane(REG_PLANE5, pack_plane(0, 16384, -16384, -50));
        add_box(16'h0020, -32768, -32768, -32768,  32767,  32767,  32767, VERDICT_PREDICT);
        add_box(16'h0021, -32768, -32768, -32768, -32768, -32768, -32768, VERDICT_PREDICT);
        add_box(16'h0022,  32767,  32767,  32767,  32767,  32767,  32767, VERDICT_PREDICT);
        add_box(16'h0023, -20000, -20000, -20000, -10000, -10000, -10000, VERDICT_PREDICT);
        add_box(16'h0024, -32768, -32768, -32768,      0,      0,      0, VERDICT_PREDICT);
        add_box(16'h0025,      0,      0,      0,      0,      0,      0, VERDICT_PREDICT);
        add_box(16'h0026,     50,    -50,     50,     60,    -40,     60, VERDICT_PREDICT);
    endfunction

    // ------------------------------------------------------------------
    // Random stimulus
    // ------------------------------------------------------------------

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(0, 4))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            3:       return 1;
            default: return -1;
        endcase
    endfunction

    function automatic int signed_span(int m);
        return int'($urandom_range(0, 2 * m)) - m;
    endfunction

    // Mix zero planes, frustum-like planes (normals within +-1.0, w pulling
    // inward), extreme parts, and raw 64-bit patterns.
    function automatic logic [PLANE_W-1:0] rand_plane();
        case ($urandom_range(0, 9))
            0, 1:
                return '0;
            2, 3, 4, 5:
                return pack_plane(signed_span(16384), signed_span(16384),
                                  signed_span(16384), -int'($urandom_range(0, 32768)));
            6, 7:
                return pack_plane(pick_extreme(), pick_extreme(),
                                  pick_extreme(), pick_extreme());
            default:
                return {$urandom, $urandom};
        endcase
    endfunction

    // Small boxes near the origin survive frustum-like planes; raw and
    // extreme corners push the sums to their limits.
    function automatic box_s rand_box();
        box_s b;
        int   lo [3];
        int   hi [3];
        int   c;
        int   e;
        int   mode;
        mode  = $urandom_range(0, 9);
        b.tag = FIELD_W'($urandom);
        for (int a = 0; a < 3; a++)
        begin
            case (mode)
                0, 1, 2, 3:
                begin
                    c     = signed_span(2000);
                    e     = $urandom_range(0, 1000);
                    lo[a] = c - e;
                    hi[a] = c + e;
                    if ($urandom_range(0, 15) == 0)
                    begin
                        lo[a] = c + e;
                        hi[a] = c - e;
                    end
                end
                4, 5, 6:
                begin
                    lo[a] = $urandom;
                    hi[a] = $urandom;
                end
                7:
                begin
                    lo[a] = pick_extreme();
                    hi[a] = pick_extreme();
                end
                default:
                begin
                    c     = signed_span(32767);
                    e     = signed_span(32767);
                    lo[a] = (c < e) ? c : e;
                    hi[a] = (c < e) ? e : c;
                end
            endcase
        end
        b.lo_x = lo[0][FIELD_W-1:0];
        b.lo_y = lo[1][FIELD_W-1:0];
        b.lo_z = lo[2][FIELD_W-1:0];
        b.hi_x = hi[0][FIELD_W-1:0];
        b.hi_y = hi[1][FIELD_W-1:0];
        b.hi_z = hi[2][FIELD_W-1:0];
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Drivers. Every task returns in the time step of a rising edge, so
    // each signal gets at most one nonblocking update per step.
    // ------------------------------------------------------------------

    // Drop valid, wait for every owed verdict, then let the chain settle.
    task automatic wait_drained();
        if (valid_up)
        begin
            in_valid <= 1'b0;
            valid_up = 1'b0;
        end
        while (awaited_verdicts.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    // Write one register; consecutive writes keep the enable high.
    task automatic write_plane(plane_reg_e idx, logic [PLANE_W-1:0] value);
        if (valid_up)
            wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx < REG_COUNT)
            plane_shadow[idx] = value;
        we_up = 1'b1;
        @(posedge clk);
    endtask

    // Present one box and hold it until the transaction completes, then
    // record the verdict the block owes for it.
    task automatic send_box(box_s b, verdict_e v, bit no_gaps);
        verdict_s owed;
        int       gap;
        if (we_up)
        begin
            cfg_we <= 1'b0;
            we_up = 1'b0;
            @(posedge clk);
        end
        gap = no_gaps ? 0 : gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            valid_up = 1'b0;
            repeat (gap) @(posedge clk);
        end
        owed.tag = b.tag;
        case (v)
            VERDICT_KEEP: owed.keep = 1'b1;
            VERDICT_CULL: owed.keep = 1'b0;
            default:      owed.keep = box_survives(b);
        endcase
        in_valid <= 1'b1;
        box_tag  <= b.tag;
        min_x    <= b.lo_x;
        min_y    <= b.lo_y;
        min_z    <= b.lo_z;
        max_x    <= b.hi_x;
        max_y    <= b.hi_y;
        max_z    <= b.hi_z;
        valid_up = 1'b1;
        // Sample stall mid-cycle: it is settled there and holds to the edge.
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        awaited_verdicts.insert(awaited_verdicts.size(), owed);
    endtask

    // Output stall: stretches with none, mostly short and now and then long, broken by bursts of stall.
    initial
    begin : stall_pattern
        int run;
        int hold;
        @(posedge rst_n);
        forever
        begin
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 6);
            repeat (run) @(posedge clk);
            hold = gap_len();
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Compare each completed result transaction with the oldest owed verdict.
    // Sample at the falling edge, where valid, stall and data are settled.
    always @(negedge clk)
    begin : check_results
        verdict_s want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_verdicts.size() == 0)
            begin
                $error("result transaction with no box outstanding, tag %h", result_tag);
                bad_fields++;
            end
            else
            begin
                want = awaited_verdicts.pop_front();
                if (result_tag !== want.tag)
                begin
                    $error("result_tag: expected %h, got %h", want.tag, result_tag);
                    bad_fields++;
                end
                if (inside_res !== want.keep)
                begin
                    $error("inside_res: expected %0b, got %0b (tag %h)",
                           want.keep, inside_res, want.tag);
                    bad_fields++;
                end
            end
        end
    end

    initial
    begin : stimulus
        bit burst;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table: plane writes wait for an empty chain.
        build_directed();
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_PLANE)
                write_plane(directed_rows[i].reg_idx, directed_rows[i].value);
            else
                send_box(directed_rows[i].box, directed_rows[i].verdict, 1'b0);
        end

        // Random phases: reprogram the planes (the first phase rewrites every
        // index, later ones keep some old values), then stream boxes. Some
        // phases send back to back with no input gaps.
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            for (int r = 0; r < CFG_SLOTS; r++)
            begin
                if (ph == 0 || $urandom_range(0, 3) != 0)
                    write_plane(plane_reg_e'(r), rand_plane());
            end
            burst = ($urandom_range(0, 3) == 0);
            repeat (PHASE_BOXES) send_box(rand_box(), VERDICT_PREDICT, burst);
        end

        // Drain, then leave spare time for any stray result.
        wait_drained();
        repeat (4) @(posedge clk);
        if (bad_fields == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Hang guard: far beyond the slowest legal run.
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/aft_pkg.sv
rtl/core/aft_cell.sv
rtl/core/aabb_frustum_cull_test.sv
tb/testbench.sv
